// ===== hdl/ipp_pkg.sv =====
// Shared constants, derived widths and controller/datapath interface types of the pacer.
`timescale 1ns / 1ps
`default_nettype none

package ipp_pkg;

    // Block dimensions.
    localparam int FIFO_DEPTH        = 8192;
    localparam int FRAME_BITS        = 48;
    localparam int MAX_PACKET_FRAMES = 16;
    localparam int TICKS_PER_SEC     = 8000;
    localparam int MILLI             = 1000;

    // Field and register widths.
    localparam int OP_W       = 2;
    localparam int KIND_W     = 2;
    localparam int PF_W       = 5;
    localparam int LEVEL_W    = 14;
    localparam int NOM_W      = 18;
    localparam int MEAS_W     = 28;
    localparam int CFG_DATA_W = 28;
    localparam int CFG_IDX_W  = 1;

    localparam logic [NOM_W-1:0] NOM_RESET = NOM_W'(48000);

    // Accumulator arithmetic. The sum of the kept remainder and the largest rate
    // bounds the dividend, which in turn bounds the quotient.
    localparam longint PERIOD        = longint'(TICKS_PER_SEC) * MILLI;
    localparam longint NOM_MAX_MILLI = ((longint'(1) << NOM_W) - 1) * MILLI;
    localparam longint MEAS_MAX      = (longint'(1) << MEAS_W) - 1;
    localparam longint MAX_RATE      = (NOM_MAX_MILLI > MEAS_MAX) ? NOM_MAX_MILLI : MEAS_MAX;
    localparam longint MAX_SUM       = MAX_RATE + PERIOD - 1;
    localparam int     SUM_W         = $clog2(MAX_SUM + 1);
    localparam int     PHASE_W       = $clog2(PERIOD);
    localparam int     QBITS         = $clog2(MAX_SUM / PERIOD + 1);

    // Division by the period as a multiplication by its rounded-up reciprocal.
    // With the shift set to the dividend width plus the period width the
    // quotient is exact for every dividend below two to the dividend width.
    localparam int     RECIP_SHIFT = SUM_W + PHASE_W;
    localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + PERIOD - 1) / PERIOD;
    localparam int     RECIP_W     = $clog2(RECIP + 1);
    localparam int     PROD_W      = SUM_W + RECIP_W;

    // FIFO and packet counters.
    localparam int ADDR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int FR_W   = $clog2(MAX_PACKET_FRAMES + 1);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH    = OP_W'(0);
    localparam logic [OP_W-1:0] OP_TICK    = OP_W'(1);
    localparam logic [OP_W-1:0] OP_RESTART = OP_W'(2);

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_PUSH    = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_SLOT    = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_RESTART = KIND_W'(2);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURED = CFG_IDX_W'(1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic push;
        logic rate_load;
        logic add;
        logic div_step;
        logic clamp;
        logic slot_read;
        logic emit_slot;
        logic emit_empty;
        logic restart;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frames_zero;
        logic slot_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hdl/ipp_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ipp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ipp_dp.sv =====
// Datapath of the pacer: rate registers, phase accumulator, divider, FIFO and result register.
`timescale 1ns / 1ps
`default_nettype none

module ipp_dp
    import ipp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic [FRAME_BITS-1:0] i_frame_in,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic      [KIND_W-1:0]     o_kind,
    output logic      [FRAME_BITS-1:0] o_frame_out,
    output logic                       o_frame_real,
    output logic                       o_accepted,
    output logic      [PF_W-1:0]       o_packet_frames,
    output logic      [LEVEL_W-1:0]    o_fifo_level,
    output logic                       o_last
);

    logic [NOM_W-1:0]      r_nominal;
    logic [MEAS_W-1:0]     r_measured;
    logic [PHASE_W-1:0]    r_phase;
    logic [SUM_W-1:0]      r_rate;
    logic [SUM_W-1:0]      r_work;
    logic [QBITS-1:0]      r_quot;
    logic [FR_W-1:0]       r_frames;
    logic [FR_W-1:0]       r_slot;
    logic                  r_real;
    logic [FRAME_BITS-1:0] r_frame_in;
    logic [ADDR_W-1:0]     r_wr_idx;
    logic [ADDR_W-1:0]     r_rd_idx;
    logic [CNT_W-1:0]      r_count;

    logic [SUM_W-1:0]      n_rate;
    logic [CNT_W-1:0]      n_count;
    logic                  w_can_push;
    logic                  w_wr_en;
    logic                  w_pop;
    logic                  w_slot_last;
    logic [PROD_W-1:0]     w_prod;
    logic [SUM_W-1:0]      w_rem;
    logic [FRAME_BITS-1:0] w_rd_data;

    // The measured rate wins whenever it is nonzero.
    assign n_rate = (r_measured != '0) ? SUM_W'(r_measured)
                                       : SUM_W'(r_nominal) * SUM_W'(MILLI);

    // The quotient comes from one multiplication by the reciprocal of the period,
    // and the remainder from the registered quotient in the following cycle.
    assign w_prod = PROD_W'(r_work) * PROD_W'(RECIP);
    assign w_rem  = r_work - SUM_W'(r_quot) * SUM_W'(PERIOD);

    assign w_can_push  = (r_count != CNT_W'(FIFO_DEPTH));
    assign w_wr_en     = i_cmd.push && w_can_push;
    assign w_pop       = i_cmd.slot_read && (r_count != '0) && (r_frames != '0);
    assign w_slot_last = (r_slot == r_frames - 1'b1);

    always_comb begin
        n_count = r_count;
        if (w_wr_en) begin
            n_count = r_count + 1'b1;
        end else if (w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    assign o_stat.frames_zero = (r_frames == '0);
    assign o_stat.slot_last   = w_slot_last;

    ipp_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (r_frame_in),
        .i_rd_en   (w_pop),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_data)
    );

    // Control state: rate registers, accumulator and FIFO pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal  <= NOM_RESET;
            r_measured <= '0;
            r_phase    <= '0;
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NOMINAL:  r_nominal  <= i_cfg_data[NOM_W-1:0];
                    CFG_MEASURED: r_measured <= i_cfg_data[MEAS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clamp) begin
                r_phase <= PHASE_W'(w_rem);
            end else if (i_cmd.restart) begin
                r_phase <= '0;
            end
            if (w_wr_en) begin
                r_wr_idx <= (r_wr_idx == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
            end
            if (w_pop) begin
                r_rd_idx <= (r_rd_idx == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Working registers and the result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_frame_in <= i_frame_in;
        end
        if (i_cmd.rate_load) begin
            r_rate <= n_rate;
        end
        if (i_cmd.add) begin
            r_work <= SUM_W'(r_phase) + r_rate;
        end
        if (i_cmd.div_step) begin
            r_quot <= w_prod[RECIP_SHIFT +: QBITS];
        end
        if (i_cmd.clamp) begin
            r_slot <= '0;
            if (int'(r_quot) > MAX_PACKET_FRAMES) begin
                r_frames <= FR_W'(MAX_PACKET_FRAMES);
            end else begin
                r_frames <= FR_W'(r_quot);
            end
        end
        if (i_cmd.slot_read) begin
            r_real <= w_pop;
        end
        if (i_cmd.emit_slot) begin
            r_slot <= r_slot + 1'b1;
        end

        if (i_cmd.push) begin
            o_kind          <= KIND_PUSH;
            o_frame_out     <= '0;
            o_frame_real    <= 1'b0;
            o_accepted      <= w_can_push;
            o_packet_frames <= '0;
            o_fifo_level    <= LEVEL_W'(n_count);
            o_last          <= 1'b1;
        end else if (i_cmd.emit_slot) begin
            o_kind          <= KIND_SLOT;
            o_frame_out     <= r_real ? w_rd_data : '0;
            o_frame_real    <= r_real;
            o_accepted      <= 1'b0;
            o_packet_frames <= PF_W'(r_frames);
            o_fifo_level    <= LEVEL_W'(r_count);
            o_last          <= w_slot_last;
        end else if (i_cmd.emit_empty || i_cmd.restart) begin
            o_kind          <= i_cmd.restart ? KIND_RESTART : KIND_SLOT;
            o_frame_out     <= '0;
            o_frame_real    <= 1'b0;
            o_accepted      <= 1'b0;
            o_packet_frames <= '0;
            o_fifo_level    <= LEVEL_W'(r_count);
            o_last          <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ipp_ctrl.sv =====
// Controller state machine of the pacer: sequences push, tick and restart work.
`timescale 1ns / 1ps
`default_nettype none

module ipp_ctrl
    import ipp_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [OP_W-1:0] i_operation,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output t_dp_cmd              o_cmd,
    input  wire t_dp_stat        i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_RATE,
        S_ADD,
        S_DIV,
        S_CLAMP,
        S_READ,
        S_EMIT,
        S_EMPTY,
        S_RESTART
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic              r_out_valid;
    logic              w_free;
    logic              w_load;

    // The result register can take a new result when empty or being drained.
    assign w_free      = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd            = '0;
        o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.push       = (r_state == S_PUSH) && w_free;
        o_cmd.rate_load  = (r_state == S_RATE);
        o_cmd.add        = (r_state == S_ADD);
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.clamp      = (r_state == S_CLAMP);
        o_cmd.slot_read  = (r_state == S_READ);
        o_cmd.emit_slot  = (r_state == S_EMIT) && w_free;
        o_cmd.emit_empty = (r_state == S_EMPTY) && w_free;
        o_cmd.restart    = (r_state == S_RESTART) && w_free;
    end

    assign w_load = o_cmd.push || o_cmd.emit_slot || o_cmd.emit_empty || o_cmd.restart;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_operation)
                        OP_PUSH:    n_state = S_PUSH;
                        OP_TICK:    n_state = S_RATE;
                        OP_RESTART: n_state = S_RESTART;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_PUSH:    if (w_free) n_state = S_IDLE;
            S_RATE:    n_state = S_ADD;
            S_ADD:     n_state = S_DIV;
            S_DIV:     n_state = S_CLAMP;
            S_CLAMP:   n_state = S_READ;
            S_READ:    n_state = i_stat.frames_zero ? S_EMPTY : S_EMIT;
            S_EMIT: begin
                if (w_free) begin
                    n_state = i_stat.slot_last ? S_IDLE : S_READ;
                end
            end
            S_EMPTY:   if (w_free) n_state = S_IDLE;
            S_RESTART: if (w_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/iso_playback_pacer_fifo.sv =====
// Top level of the isochronous playback pacer with its frame FIFO.
//
// Usage. Input items arrive on the in channel (i_in_valid / o_in_ready) with an
// operation code and a frame. A push stores the frame in an 8192-entry FIFO and
// returns one reply that says whether it was stored. A microframe tick advances a
// phase accumulator by the rate in millihertz, divides by the tick period to get
// the frame count of the packet (clamped to 16), and returns one result per slot:
// a popped frame, or zero when the FIFO has run dry; a tick that yields no frame
// returns a single empty-packet marker. Restart clears the accumulator and returns
// one reply. Each result is a transfer on the out channel, the final one of an item
// carries o_last, and operation code 3 is dropped silently.
// Timing. Items are handled one at a time. A push or restart result is loaded in
// the push or restart state that follows its transfer in, and the next item can
// follow once the block is back in idle. A tick steps through states for the rate,
// the sum, a reciprocal multiplication for the quotient, and the clamp with the
// remainder, then a read state and an emit state for each slot, set by the
// registered FIFO read, or an empty state for a packet with no frame. A stalled
// receiver holds the result register and the block waits. Reset clears the
// accumulator and FIFO pointers and reloads the rate registers; the configuration
// port always accepts.
`timescale 1ns / 1ps
`default_nettype none

module iso_playback_pacer_fifo
    import ipp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input item channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [FRAME_BITS-1:0] i_frame_in,
    // Result channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [KIND_W-1:0]     o_kind,
    output logic      [FRAME_BITS-1:0] o_frame_out,
    output logic                       o_frame_real,
    output logic                       o_accepted,
    output logic      [PF_W-1:0]       o_packet_frames,
    output logic      [LEVEL_W-1:0]    o_fifo_level,
    output logic                       o_last,
    // Configuration write channel.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Register writes complete in the cycle they are offered.
    assign o_cfg_ready = 1'b1;

    // The controller decides what happens each cycle and owns both handshakes.
    ipp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // The datapath holds the arithmetic, the FIFO and the result payload.
    ipp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_frame_in      (i_frame_in),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_kind          (o_kind),
        .o_frame_out     (o_frame_out),
        .o_frame_real    (o_frame_real),
        .o_accepted      (o_accepted),
        .o_packet_frames (o_packet_frames),
        .o_fifo_level    (o_fifo_level),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

// ===== hdl/ipp_chk.sv =====
// Port-level assertion checker for the pacer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ipp_chk
    import ipp_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [KIND_W-1:0]     o_kind,
    input wire logic [FRAME_BITS-1:0] o_frame_out,
    input wire logic                  o_frame_real,
    input wire logic                  o_accepted,
    input wire logic [PF_W-1:0]       o_packet_frames,
    input wire logic                  o_last
);

    // A stalled result stays valid and keeps its kind, frame and last flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_frame_out) && $stable(o_last))
        else $error("result changed while stalled");

    // Push and restart replies are single results with no slot data.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_PUSH || o_kind == KIND_RESTART)
            |-> o_last && !o_frame_real && o_frame_out == '0 && o_packet_frames == '0)
        else $error("push or restart reply malformed");

    // A zero-filled slot carries a zero frame.
    a_zero_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_SLOT && !o_frame_real |-> o_frame_out == '0)
        else $error("zero-filled slot has data");

    // Slots never report acceptance and stay within the packet clamp.
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_SLOT
            |-> !o_accepted && int'(o_packet_frames) <= MAX_PACKET_FRAMES)
        else $error("slot result out of range");

    // A restart reply never reports acceptance.
    a_kind_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_RESTART |-> !o_accepted)
        else $error("restart reply flagged as accepted");

endmodule

bind iso_playback_pacer_fifo ipp_chk u_ipp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_kind          (o_kind),
    .o_frame_out     (o_frame_out),
    .o_frame_real    (o_frame_real),
    .o_accepted      (o_accepted),
    .o_packet_frames (o_packet_frames),
    .o_last          (o_last)
);

`default_nettype wire
